// ===== hdl/smc_pkg.sv =====
// shared types, constants and base-coding functions for the substitution matrix counter
package smc_pkg;

  localparam int COUNT_WIDTH_DEF = 48;
  localparam int COUNT_WIDTH_MIN = 16;
  localparam int COUNT_WIDTH_MAX = 64;
  localparam int OUT_COUNT_W     = 48;
  localparam int INDEX_W         = 4;
  localparam int NUM_COUNTS      = 16;
  localparam int RUN_W           = 32;
  localparam int QUARTER_W       = RUN_W - 2;
  localparam int QUEUE_DEPTH     = 2;

  localparam int S_TDATA_W = 56;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 56;

  localparam logic [7:0] BASE_MIN = 8'h41;
  localparam logic [INDEX_W-1:0] DIAG_T = 4'd12;

  typedef enum logic [1:0] {
    OP_PAIR   = 2'd0,
    OP_ANCHOR = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_BUMP  = 2'd0,
    CMD_SPLIT = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [INDEX_W-1:0]   index;
    logic [QUARTER_W-1:0] quarter;
    logic [1:0]           rem;
  } cmd_t;

  function automatic logic is_base(input logic [7:0] b);
    return (b >= BASE_MIN) && !b[7];
  endfunction

  // bits 2:1 mapped so that A0 C1 G2 T3
  function automatic logic [1:0] base_code(input logic [7:0] b);
    return {b[2], b[2] ^ b[1]};
  endfunction

  function automatic logic [INDEX_W-1:0] pair_index(input logic [1:0] s, input logic [1:0] q);
    logic [1:0] col;
    col = (s >= q) ? (s - q) : q;
    return {s, col};
  endfunction

endpackage

// ===== hdl/substitution_matrix_counter_unit.sv =====
// top level of the substitution matrix counter
// The unit takes one word per clock cycle on the slave stream while the queue has room and
// keeps sixteen saturating counters of COUNT_WIDTH bits. The front end classifies each word
// (pair, anchor, read, clear), drops pairs with a non-base byte and, in count mode, anchors
// with a non-base subject; a two-entry command queue feeds the back end, which carries out
// one command per cycle unless a read waits on a stalled output, so the sustained rate is
// one word per cycle. A read word's counter is registered to the master stream when the read
// leaves the queue; its value reflects every word accepted before it. Input stalls only when
// the output register holds an untaken read result and the queue has filled up behind it.
// count_mode should be written while no words are in flight.
module substitution_matrix_counter_unit #(
  parameter int COUNT_WIDTH = smc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // subject_char, query_char, run_length, read_index, zero pad
  input  logic [smc_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // op
  input  logic [smc_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // count_value, count_index, zero pad
  output logic [smc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import smc_pkg::*;

  logic q_ready;
  logic q_push;
  cmd_t q_cmd;
  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  smc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  smc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .ready    (q_ready),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  smc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== hdl/smc_front.sv =====
// front end: holds the mode register and turns input words into counter commands
module smc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [smc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input  logic [smc_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  input  logic                           q_ready,
  output logic                           q_push,
  output smc_pkg::cmd_t                  q_cmd
);
  import smc_pkg::*;

  logic       count_mode;
  logic       needed;
  op_t        op;
  logic [7:0] subject_char;
  logic [7:0] query_char;
  logic [RUN_W-1:0]   run_length;
  logic [INDEX_W-1:0] read_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_mode <= 1'b0;
    end else if (cfg_we) begin
      count_mode <= cfg_wdata;
    end
  end

  assign op           = op_t'(s_axis_tuser);
  assign subject_char = s_axis_tdata[7:0];
  assign query_char   = s_axis_tdata[15:8];
  assign run_length   = s_axis_tdata[47:16];
  assign read_index   = s_axis_tdata[51:48];

  always_comb begin
    q_cmd.kind    = CMD_BUMP;
    q_cmd.index   = '0;
    q_cmd.quarter = run_length[RUN_W-1:2];
    q_cmd.rem     = run_length[1:0];
    needed        = 1'b0;
    case (op)
      OP_PAIR: begin
        if (is_base(subject_char) && is_base(query_char)) begin
          needed      = 1'b1;
          q_cmd.index = pair_index(base_code(subject_char), base_code(query_char));
        end
      end
      OP_ANCHOR: begin
        if (!count_mode) begin
          needed     = 1'b1;
          q_cmd.kind = CMD_SPLIT;
        end else if (is_base(subject_char)) begin
          needed      = 1'b1;
          q_cmd.index = {base_code(subject_char), 2'b00};
        end
      end
      OP_READ: begin
        needed      = 1'b1;
        q_cmd.kind  = CMD_READ;
        q_cmd.index = read_index;
      end
      OP_CLEAR: begin
        needed     = 1'b1;
        q_cmd.kind = CMD_CLEAR;
      end
      default: begin
        needed = 1'b0;
      end
    endcase
  end

  // skipped words need no queue entry
  assign s_axis_tready = q_ready;
  assign q_push        = s_axis_tvalid && q_ready && needed;

endmodule

// ===== hdl/smc_queue.sv =====
// short command queue between front and back end
module smc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  smc_pkg::cmd_t push_cmd,
  output logic          ready,
  output logic          valid,
  output smc_pkg::cmd_t head,
  input  logic          pop
);
  import smc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_pop;

  assign ready  = (fill != DEPTH_C);
  assign valid  = (fill != '0);
  assign head   = slots[rd_ptr];
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_C) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_C) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= DEPTH_C)
    else $error("queue fill beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && !ready))
    else $error("push into full queue");
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (push && !do_pop) |=> fill == $past(fill) + 1'b1)
    else $error("queue fill did not follow a push");

endmodule

// ===== hdl/smc_back.sv =====
// back end: sixteen saturating counters, clear and read with output register
module smc_back #(
  parameter int COUNT_WIDTH = smc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  smc_pkg::cmd_t                 q_head,
  output logic                          q_pop,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [smc_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import smc_pkg::*;

  localparam int SUM_W = ((COUNT_WIDTH > RUN_W) ? COUNT_WIDTH : RUN_W) + 1;
  localparam logic [SUM_W-1:0] MAX_C = {{(SUM_W-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

  logic [COUNT_WIDTH-1:0] counts      [NUM_COUNTS];
  logic [COUNT_WIDTH-1:0] counts_next [NUM_COUNTS];
  logic [RUN_W-1:0]       amount      [NUM_COUNTS];
  logic [SUM_W-1:0]       sums        [NUM_COUNTS];
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic [OUT_COUNT_W-1:0] rd_value;
  logic                   out_busy;

  assign out_busy = m_axis_tvalid && !m_axis_tready;
  assign q_pop    = q_valid && !((q_head.kind == CMD_READ) && out_busy);

  always_comb begin
    for (int k = 0; k < NUM_COUNTS; k++) begin
      amount[k] = '0;
      case (q_head.kind)
        CMD_BUMP: begin
          if (q_head.index == INDEX_W'(k)) amount[k] = RUN_W'(1);
        end
        CMD_SPLIT: begin
          if (INDEX_W'(k) == DIAG_T) begin
            amount[k] = RUN_W'(q_head.quarter) + RUN_W'(q_head.rem);
          end else if (k % 4 == 0) begin
            amount[k] = RUN_W'(q_head.quarter);
          end
        end
        default: begin
          amount[k] = '0;
        end
      endcase
      sums[k] = SUM_W'(counts[k]) + SUM_W'(amount[k]);
      counts_next[k] = (sums[k] > MAX_C) ? {COUNT_WIDTH{1'b1}} : sums[k][COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_COUNTS; k++) counts[k] <= '0;
    end else if (q_pop) begin
      for (int k = 0; k < NUM_COUNTS; k++) begin
        if (q_head.kind == CMD_CLEAR) begin
          counts[k] <= '0;
        end else begin
          counts[k] <= counts_next[k];
        end
      end
    end
  end

  assign rd_cnt = counts[q_head.index];

  generate
    if (COUNT_WIDTH >= OUT_COUNT_W) begin : g_trunc
      assign rd_value = rd_cnt[OUT_COUNT_W-1:0];
    end else begin : g_ext
      assign rd_value = {{(OUT_COUNT_W-COUNT_WIDTH){1'b0}}, rd_cnt};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (q_pop && (q_head.kind == CMD_READ)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_head.kind == CMD_READ)) begin
      m_axis_tdata <= {{(M_TDATA_W-OUT_COUNT_W-INDEX_W){1'b0}}, q_head.index, rd_value};
    end
  end

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_head.kind == CMD_CLEAR) |=> (counts[0] == '0 && counts[12] == '0))
    else $error("counters not zero after clear");
  a_read_shows: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_head.kind == CMD_READ) |=> m_axis_tvalid)
    else $error("read word not presented");
  a_no_decrease: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_head.kind == CMD_CLEAR) |=> counts[12] >= $past(counts[12]))
    else $error("counter went down without clear");

endmodule
